// ----- rtl/core/serial_line_keyword_recognizer_macros.svh -----
// assertion macros for the serial line keyword recogniser
// used by serial_line_keyword_recognizer.sv in rtl/core; the macros expect aclk and aresetn in scope
`ifndef SERIAL_LINE_KEYWORD_RECOGNIZER_MACROS_SVH
`define SERIAL_LINE_KEYWORD_RECOGNIZER_MACROS_SVH
`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define SLKR_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("slkr: invariant violated");
// consequence holds in the same cycle as the antecedent
`define SLKR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("slkr: same-cycle implication violated");
// consequence holds in the cycle after the antecedent
`define SLKR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("slkr: next-cycle implication violated");
`else
`define SLKR_ASSERT_ALWAYS(label, expr)
`define SLKR_ASSERT_IMPL(label, ante, cons)
`define SLKR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/core/slkr_pkg.sv -----
// package for the serial line keyword recogniser: keyword table, widths, result struct
// no dependencies
`default_nettype none

package slkr_pkg;

    localparam int unsigned TABLE_SIZE        = 8;
    localparam int unsigned KEYWORD_COUNT_DEF = 8;
    localparam int unsigned MAX_KW_LEN        = 22;
    localparam int unsigned POS_W             = 5;
    localparam int unsigned CODE_W            = 3;
    localparam int unsigned BYTE_W            = 8;
    localparam int unsigned KW_BITS           = MAX_KW_LEN * BYTE_W;

    localparam logic [BYTE_W-1:0] CH_CR   = 8'd13;
    localparam logic [BYTE_W-1:0] CH_LF   = 8'd10;
    localparam logic [POS_W-1:0]  POS_MAX = '1;

    // strings are right-justified: the first character sits highest
    localparam logic [KW_BITS-1:0] KW_TEXT [TABLE_SIZE] = '{
        {"led_all", "_on"},
        {"led_all", "_off"},
        {"shift_left", "_ledon"},
        {"shift_right", "_ledon"},
        {"shift_left_keep", "_ledon"},
        {"shift_right_keep", "_ledon"},
        "floweron",
        "floweroff"
    };

    localparam logic [POS_W-1:0] KW_LEN [TABLE_SIZE] = '{
        5'd10, 5'd11, 5'd16, 5'd17, 5'd21, 5'd22, 5'd8, 5'd9
    };

    typedef struct packed {
        logic              valid;
        logic              matched;
        logic [CODE_W-1:0] code;
    } result_t;

    // character of keyword k at line position pos, valid only for pos below its length
    function automatic logic [BYTE_W-1:0] kw_char(input logic [CODE_W-1:0] k,
                                                   input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] idx;
        idx = KW_LEN[k] - pos - 1'b1;
        return KW_TEXT[k][{idx, 3'b000} +: BYTE_W];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/slkr_track.sv -----
// per-line keyword tracking: position counter, live bits, match decision at the terminator
// depends on slkr_pkg
`default_nettype none

module slkr_track #(
    parameter int unsigned KEYWORD_COUNT = slkr_pkg::KEYWORD_COUNT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          step,
    input  wire logic [slkr_pkg::BYTE_W-1:0]   rx_byte,
    output slkr_pkg::result_t                  result
);
    import slkr_pkg::*;

    localparam int unsigned ACTIVE = (KEYWORD_COUNT < TABLE_SIZE) ? KEYWORD_COUNT : TABLE_SIZE;

    logic [POS_W-1:0]      pos_reg,   pos_next;
    logic [TABLE_SIZE-1:0] alive_reg, alive_next;
    logic [TABLE_SIZE-1:0] hit;
    logic [POS_W-1:0]      pos_inc;
    logic                  is_term;
    logic                  matched;
    logic [CODE_W-1:0]     code;

    always_comb begin
        is_term    = (rx_byte == CH_CR) || (rx_byte == CH_LF);
        alive_next = alive_reg;
        hit        = '0;
        for (int k = 0; k < TABLE_SIZE; k++) begin
            if (k < ACTIVE) begin
                if ((pos_reg < KW_LEN[k]) && (kw_char(CODE_W'(k), pos_reg) != rx_byte)) begin
                    alive_next[k] = 1'b0;
                end
                hit[k] = alive_reg[k] && (pos_reg >= KW_LEN[k]);
            end
        end
        // lowest index wins
        matched = 1'b0;
        code    = '0;
        for (int k = TABLE_SIZE - 1; k >= 0; k--) begin
            if (hit[k]) begin
                matched = 1'b1;
                code    = CODE_W'(k);
            end
        end
        pos_inc = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
        if (is_term) begin
            pos_next = '0;
        end else begin
            pos_next = pos_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            alive_reg <= '1;
        end else if (step) begin
            pos_reg <= pos_next;
            if (is_term) begin
                alive_reg <= '1;
            end else begin
                alive_reg <= alive_next;
            end
        end
    end

    assign result.valid   = is_term;
    assign result.matched = matched;
    assign result.code    = code;

endmodule

`default_nettype wire

// ----- rtl/core/slkr_result_stage.sv -----
// result register on the m_ side of the keyword recogniser
// depends on slkr_pkg
`default_nettype none

module slkr_result_stage (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          load,
    input  slkr_pkg::result_t                  res_in,
    input  wire logic                          m_ready,
    output logic                               m_valid,
    output logic                               m_matched,
    output logic [slkr_pkg::CODE_W-1:0]        m_command_code
);
    import slkr_pkg::*;

    logic              valid_reg,   valid_next;
    logic              matched_reg;
    logic [CODE_W-1:0] code_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            matched_reg <= res_in.matched;
            code_reg    <= res_in.code;
        end
    end

    assign m_valid        = valid_reg;
    assign m_matched      = matched_reg;
    assign m_command_code = code_reg;

endmodule

`default_nettype wire

// ----- rtl/core/serial_line_keyword_recognizer.sv -----
// serial line keyword recogniser: one byte per cycle, one result per cr or lf
// path: an accepted byte is held in the input register and evaluated by the tracker, and
// a terminator's result is then loaded into the output register, which drives m_valid
// throughput: one byte every cycle; a terminator only waits while the output register is full
// reset: synchronous active-low aresetn clears the handshake state, the position counter
// and sets every keyword live; payload registers are not reset
`default_nettype none
`include "serial_line_keyword_recognizer_macros.svh"

module serial_line_keyword_recognizer #(
    parameter int unsigned KEYWORD_COUNT = slkr_pkg::KEYWORD_COUNT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [slkr_pkg::BYTE_W-1:0]   s_rx_byte,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_matched,
    output logic [slkr_pkg::CODE_W-1:0]        m_command_code
);
    import slkr_pkg::*;

    // input register: holds one request until the tracker consumes it
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;

    result_t res;
    logic    out_free;
    logic    advance;
    logic    s_fire;

    // the output register is free when empty or being drained this cycle
    assign out_free = !m_valid || m_ready;
    // a line character always moves on; a terminator needs room for its result
    assign advance  = in_valid_reg && (!res.valid || out_free);
    assign s_ready  = !in_valid_reg || advance;
    assign s_fire   = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // keyword compares and match decision for the registered byte
    slkr_track #(
        .KEYWORD_COUNT (KEYWORD_COUNT)
    ) u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .result  (res)
    );

    // result register towards the m_ side
    slkr_result_stage u_result (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (advance && res.valid),
        .res_in         (res),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_matched      (m_matched),
        .m_command_code (m_command_code)
    );

    // an unmatched result always carries code zero
    `SLKR_ASSERT_IMPL(a_unmatched_code_zero, m_valid && !m_matched, m_command_code == '0)
    // a terminator that is consumed shows up as a pending result next cycle
    `SLKR_ASSERT_NEXT(a_term_gives_result, advance && res.valid, m_valid)
    // the input side only stalls behind a terminator blocked by a full output
    `SLKR_ASSERT_IMPL(a_stall_reason, in_valid_reg && !s_ready,
                      res.valid && m_valid && !m_ready)

endmodule

`default_nettype wire
